[hw/rtl/sifp_pkg.sv]
// Shared types and constants for the scanf integer field parser.
// No dependencies; used by every module of the block.
package sifp_pkg;

    // Parse phases
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_START  = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    // Base codes, shared by base_mode register and base in use
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_OCT  = 2'd1;
    localparam logic [1:0] BASE_DEC  = 2'd2;
    localparam logic [1:0] BASE_HEX  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 1'b1;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [7:0] in_char;
        logic       at_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] field_value;
        logic [5:0]         chars_taken;
        logic               char_consumed;
    } t_out_item;

    // Control part of the field state (accumulator travels apart)
    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] base;
        logic [5:0] count;
        logic       neg;
    } t_field_state;

endpackage

[hw/rtl/sifp_step.sv]
// Combinational next-state and result logic for one input byte.
// Depends on sifp_pkg.
module sifp_step #(
    parameter int VALUE_BITS    = 32,
    parameter int DEFAULT_WIDTH = 32
) (
    input  sifp_pkg::t_in_item     i_item,
    input  logic [1:0]             i_base_mode,
    input  logic [5:0]             i_max_width,
    input  sifp_pkg::t_field_state i_state,
    input  logic [VALUE_BITS-1:0]  i_acc,
    output sifp_pkg::t_field_state o_state,
    output logic [VALUE_BITS-1:0]  o_acc,
    output logic                   o_res_valid,
    output sifp_pkg::t_out_item    o_res
);

    localparam logic [5:0] NOT_DIGIT = 6'd63;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = NOT_DIGIT;
        if (c >= 8'h30 && c <= 8'h39)      d = 6'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h5A) d = 6'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h7A) d = 6'(c - 8'h61 + 8'd10);
        return d;
    endfunction

    logic [5:0]            w;
    logic [7:0]            c;
    logic                  go;
    logic                  fin;
    logic                  used;
    logic [5:0]            d;
    logic [5:0]            radix;
    logic                  take;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] signed_v;
    sifp_pkg::t_field_state s;
    logic [VALUE_BITS-1:0] acc;

    always_comb begin
        w = (i_max_width == 6'd0 || i_max_width > 6'(DEFAULT_WIDTH))
            ? 6'(DEFAULT_WIDTH) : i_max_width;
        c     = i_item.in_char;
        s     = i_state;
        acc   = i_acc;
        go    = 1'b0;
        fin   = 1'b0;
        used  = 1'b0;
        d     = digit_of(c);
        radix = 6'd10;
        take  = 1'b0;
        scaled = '0;

        if (i_item.at_end) begin
            fin = 1'b1;
        end else begin
            go = 1'b1;
            if (s.phase == sifp_pkg::PH_SKIP) begin
                if (c == sifp_pkg::CH_SPACE || c == sifp_pkg::CH_TAB
                        || c == sifp_pkg::CH_NL) begin
                    go = 1'b0;
                end else if (c == sifp_pkg::CH_MINUS || c == sifp_pkg::CH_PLUS) begin
                    go    = 1'b0;
                    s.neg = (c == sifp_pkg::CH_MINUS);
                    s.count = 6'd1;
                    if (6'd1 >= w) begin
                        fin  = 1'b1;
                        used = 1'b1;
                    end else begin
                        s.phase = sifp_pkg::PH_START;
                    end
                end else begin
                    s.phase = sifp_pkg::PH_START;
                end
            end

            if (go) begin
                if (s.phase == sifp_pkg::PH_START) begin
                    if (i_base_mode == sifp_pkg::BASE_AUTO) begin
                        if (c == sifp_pkg::CH_ZERO) begin
                            go      = 1'b0;
                            s.count = s.count + 6'd1;
                            if (s.count >= w) begin
                                fin  = 1'b1;
                                used = 1'b1;
                            end else begin
                                s.phase = sifp_pkg::PH_ZERO;
                            end
                        end else begin
                            s.base = sifp_pkg::BASE_DEC;
                        end
                    end else begin
                        s.base = i_base_mode;
                    end
                    if (go) s.phase = sifp_pkg::PH_DIGITS;
                end else if (s.phase == sifp_pkg::PH_ZERO) begin
                    if (c == sifp_pkg::CH_X) begin
                        go      = 1'b0;
                        s.base  = sifp_pkg::BASE_HEX;
                        s.count = s.count + 6'd1;
                        if (s.count >= w) begin
                            fin  = 1'b1;
                            used = 1'b1;
                        end else begin
                            s.phase = sifp_pkg::PH_DIGITS;
                        end
                    end else begin
                        s.base  = sifp_pkg::BASE_OCT;
                        s.phase = sifp_pkg::PH_DIGITS;
                    end
                end
            end

            if (go) begin
                case (s.base)
                    sifp_pkg::BASE_OCT: begin
                        radix  = 6'd8;
                        scaled = acc << 3;
                    end
                    sifp_pkg::BASE_HEX: begin
                        radix  = 6'd16;
                        scaled = acc << 4;
                    end
                    default: begin
                        radix  = 6'd10;
                        scaled = (acc << 3) + (acc << 1);
                    end
                endcase
                // hex: an 'x' counts as a zero digit while value is zero
                take = (d < radix) || (s.base == sifp_pkg::BASE_HEX
                        && acc == '0 && c == sifp_pkg::CH_X);
                if (take) begin
                    acc     = scaled + VALUE_BITS'((d < radix) ? d : 6'd0);
                    s.count = s.count + 6'd1;
                    if (s.count >= w) begin
                        fin  = 1'b1;
                        used = 1'b1;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
        end

        signed_v = s.neg ? (VALUE_BITS'(0) - acc) : acc;
        o_res.field_value   = 32'(signed_v);
        o_res.chars_taken   = s.count;
        o_res.char_consumed = used;
        o_res_valid         = fin;

        if (fin) begin
            o_state = '{phase: sifp_pkg::PH_SKIP, base: sifp_pkg::BASE_AUTO,
                        count: 6'd0, neg: 1'b0};
            o_acc   = '0;
        end else begin
            o_state = s;
            o_acc   = acc;
        end
    end

endmodule

[hw/rtl/sifp_out_reg.sv]
// Result register with valid/ready handshake toward the receiver.
// Depends on sifp_pkg.
module sifp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sifp_pkg::t_out_item i_data,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output sifp_pkg::t_out_item o_data
);

    logic                r_valid;
    sifp_pkg::t_out_item r_data;

    // slot is usable this cycle if empty or being drained
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

[hw/rtl/scanf_integer_field_parser_core.sv]
// Top level of the scanf integer field parser: input register, field state,
// configuration registers. Depends on sifp_pkg, sifp_step and sifp_out_reg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one byte per
//   transfer plus an end-of-input flag. Output channel (o_out_valid /
//   i_out_ready / o_out_item) carries one result per finished field: value,
//   character count (0 = no conversion) and whether the last byte was used.
//   A result with char_consumed = 0 means the byte must be sent again.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 base_mode, 1 max_width); write only while the block is idle.
//   Data path: an accepted byte waits in the input register and is processed
//   from it into the field state; its result, if any, is registered in the
//   result register. Throughput: one byte per cycle unless a field-ending
//   byte waits on a busy result register; set by the combinational step
//   logic (one shift-add on the accumulator) feeding the field state.
//   Receiver stall: bytes that end no field keep flowing; a byte that ends a
//   field waits in the input register until the result register frees up,
//   and o_in_ready drops meanwhile.
//   Reset (synchronous, active low): field state cleared, base_mode and
//   max_width set to 0, both channels empty.
module scanf_integer_field_parser_core #(
    parameter int VALUE_BITS    = 32,
    parameter int DEFAULT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sifp_pkg::t_in_item                  i_in_item,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sifp_pkg::t_out_item                 o_out_item,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [sifp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sifp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // config registers
    logic [1:0] r_base_mode;
    logic [5:0] r_max_width;

    // input register
    logic               r_in_valid;
    sifp_pkg::t_in_item r_in;

    // field state
    sifp_pkg::t_field_state r_state;
    logic [VALUE_BITS-1:0]  r_acc;

    sifp_pkg::t_field_state n_state;
    logic [VALUE_BITS-1:0]  n_acc;
    logic                   res_valid;
    sifp_pkg::t_out_item    res;
    logic                   out_free;
    logic                   proc;

    sifp_step #(
        .VALUE_BITS    (VALUE_BITS),
        .DEFAULT_WIDTH (DEFAULT_WIDTH)
    ) u_step (
        .i_item      (r_in),
        .i_base_mode (r_base_mode),
        .i_max_width (r_max_width),
        .i_state     (r_state),
        .i_acc       (r_acc),
        .o_state     (n_state),
        .o_acc       (n_acc),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sifp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (proc && res_valid),
        .i_data  (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_item)
    );

    // held byte is processed unless it ends a field and the result slot is busy
    assign proc       = r_in_valid && (!res_valid || out_free);
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // field state advances once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: sifp_pkg::PH_SKIP, base: sifp_pkg::BASE_AUTO,
                         count: 6'd0, neg: 1'b0};
            r_acc   <= '0;
        end else if (proc) begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode <= sifp_pkg::BASE_AUTO;
            r_max_width <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sifp_pkg::CFG_BASE_MODE: r_base_mode <= i_cfg_data[1:0];
                sifp_pkg::CFG_MAX_WIDTH: r_max_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[sim/testbench.sv]
// Testbench for scanf_integer_field_parser_core: byte stream in, one result per field out.
// Self-checking against an in-file field predictor; depends on sifp_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sifp_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          MAX_IDLE      = 13;
    localparam int          SETTLE_CYCLES = 4;     // drain margin after the last owed result
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          FULL_WIDTH    = 32;
    localparam int unsigned NO_DIGIT      = 99;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scanf_integer_field_parser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Field predictor: own copy of the registers and the field in progress
    // ------------------------------------------------------------------
    logic [1:0]  cur_base_mode;
    logic [5:0]  cur_max_width;
    logic [1:0]  fld_phase;
    logic [1:0]  fld_base;
    logic [31:0] fld_acc;
    logic [5:0]  fld_count;
    logic        fld_neg;

    t_out_item   pending_results[$];   // results owed by the core, oldest first

    int fail_count     = 0;
    int bytes_accepted = 0;
    int fields_checked = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    bit no_idle        = 1'b0;         // set for stretches with back-to-back transfers

    function automatic void clear_field();
        fld_phase = PH_SKIP;
        fld_base  = BASE_AUTO;
        fld_acc   = '0;
        fld_count = '0;
        fld_neg   = 1'b0;
    endfunction

    function automatic int unsigned char_digit(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "A" && c <= "Z")
            return c - "A" + 10;
        if (c >= "a" && c <= "z")
            return c - "a" + 10;
        return NO_DIGIT;
    endfunction

    function automatic int unsigned radix_for(logic [1:0] code);
        if (code == BASE_OCT)
            return 8;
        if (code == BASE_HEX)
            return 16;
        return 10;
    endfunction

    // Closes the field: value is negated in 32-bit wrap arithmetic when signed.
    function automatic t_out_item close_field(bit used);
        t_out_item r;
        r.field_value   = fld_neg ? (32'd0 - fld_acc) : fld_acc;
        r.chars_taken   = fld_count;
        r.char_consumed = used;
        clear_field();
        return r;
    endfunction

    // Advances the field by one accepted byte; returns 1 when a result is due.
    function automatic bit parse_byte(input t_in_item it, output t_out_item r);
        logic [7:0]  c;
        int unsigned w;
        int unsigned d;
        int unsigned b;
        c = it.in_char;
        r = '0;
        w = cur_max_width;
        if (w == 0 || w > FULL_WIDTH)
            w = FULL_WIDTH;

        if (it.at_end) begin
            r = close_field(1'b0);
            return 1'b1;
        end

        if (fld_phase == PH_SKIP) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
                return 1'b0;
            if (c == CH_MINUS || c == CH_PLUS) begin
                fld_neg   = (c == CH_MINUS);
                fld_count = 1;
                if (fld_count >= w) begin
                    r = close_field(1'b1);
                    return 1'b1;
                end
                fld_phase = PH_START;
                return 1'b0;
            end
            fld_phase = PH_START;
        end

        // base is settled on the first byte after the sign, or in auto mode on the byte after a leading zero
        if (fld_phase == PH_START) begin
            if (cur_base_mode == BASE_AUTO) begin
                if (c == CH_ZERO) begin
                    fld_count++;
                    if (fld_count >= w) begin
                        r = close_field(1'b1);
                        return 1'b1;
                    end
                    fld_phase = PH_ZERO;
                    return 1'b0;
                end
                fld_base = BASE_DEC;
            end else begin
                fld_base = cur_base_mode;
            end
            fld_phase = PH_DIGITS;
        end else if (fld_phase == PH_ZERO) begin
            if (c == CH_X) begin
                fld_base = BASE_HEX;
                fld_count++;
                if (fld_count >= w) begin
                    r = close_field(1'b1);
                    return 1'b1;
                end
                fld_phase = PH_DIGITS;
                return 1'b0;
            end
            fld_base  = BASE_OCT;
            fld_phase = PH_DIGITS;
        end

        b = radix_for(fld_base);
        d = char_digit(c);
        // in hex an 'x' counts as a zero digit while nothing nonzero came yet
        if (d < b || (fld_base == BASE_HEX && fld_acc == 0 && c == CH_X)) begin
            if (d >= b)
                d = 0;
            fld_acc = fld_acc * b + d;
            fld_count++;
            if (fld_count >= w) begin
                r = close_field(1'b1);
                return 1'b1;
            end
            return 1'b0;
        end
        r = close_field(1'b0);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    // Idle cycles before a transfer; at least a third come with no gap, all of them while no_idle is set.
    function automatic int idle_cycles();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // One input transfer. A byte pushed back by a field that took characters
    // is presented again, as a caller of the parser would.
    task automatic send_byte(input logic [7:0] c, input bit at_end);
        t_in_item  it;
        t_out_item r;
        bit        resend;
        int        gap;
        it.in_char = c;
        it.at_end  = at_end;
        do begin
            gap = idle_cycles();
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_item  = it;
            i_in_valid = 1'b1;
            do @(posedge i_clk); while (!o_in_ready);
            bytes_accepted++;
            resend = 1'b0;
            if (parse_byte(it, r)) begin
                pending_results.push_back(r);
                resend = !r.char_consumed && r.chars_taken != 0 && !at_end;
            end
            @(negedge i_clk);
        end while (resend);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i], 1'b0);
    endtask

    // Waits until every owed result has arrived and the pipeline has drained.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_BASE_MODE)
            cur_base_mode = data[1:0];
        else
            cur_max_width = data;
    endtask

    // Register writes only when idle; a field may still be open (mid-field write).
    task automatic apply_settings(input logic [1:0] base, input logic [5:0] width);
        settle();
        write_reg(CFG_BASE_MODE, CFG_DATA_W'(base));
        write_reg(CFG_MAX_WIDTH, width);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Character pickers for the random fields
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit(int unsigned radix);
        int unsigned v;
        v = $urandom_range(0, radix - 1);
        if (v < 10)
            return 8'("0" + v);
        return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    // Mostly bytes that end a field in this radix; any byte now and then.
    function automatic logic [7:0] pick_stopper(int unsigned radix);
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'("g" + $urandom_range(0, 19));
            2: begin
                if (radix == 8)
                    return 8'("8" + $urandom_range(0, 1));
                if (radix == 10)
                    return 8'("a" + $urandom_range(0, 5));
                return "G";
            end
            default: return 8'($urandom_range(8'h7B, 8'hFF));   // above 'z'
        endcase
    endfunction

    // One field: blanks, sign, prefix, digits, then some way of ending it.
    task automatic send_field();
        int unsigned radix;
        int          n_dig;
        if ($urandom_range(0, 6) == 0) begin
            // noise: arbitrary bytes, end of input now and then
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            return;
        end
        repeat ($urandom_range(0, 2))
            send_byte(pick_blank(), 1'b0);
        case ($urandom_range(0, 2))
            1: send_byte(CH_PLUS, 1'b0);
            2: send_byte(CH_MINUS, 1'b0);
            default: ;
        endcase
        radix = radix_for(cur_base_mode);
        if (cur_base_mode == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: send_byte(8'("1" + $urandom_range(0, 8)), 1'b0);
                1: begin
                    send_byte(CH_ZERO, 1'b0);
                    radix = 8;
                end
                default: begin
                    send_byte(CH_ZERO, 1'b0);
                    send_byte(CH_X, 1'b0);
                    radix = 16;
                end
            endcase
        end else if (cur_base_mode == BASE_HEX && $urandom_range(0, 3) == 0) begin
            send_byte(CH_ZERO, 1'b0);
            send_byte(CH_X, 1'b0);
        end
        n_dig = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        repeat (n_dig)
            send_byte(pick_digit(radix), 1'b0);
        case ($urandom_range(0, 3))
            0: send_byte(8'($urandom_range(0, 255)), 1'b1);
            1: send_byte(pick_stopper(radix), 1'b0);
            2: send_byte(pick_blank(), 1'b0);
            default: ;   // runs into the next field
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: auto base, full width.
    task automatic test_basic_fields();
        send_text(" \t\n-12;");             // blanks skipped, ';' pushed back, then no conversion
        send_text("0xfF");
        send_byte(8'hFF, 1'b1);             // end of input, byte ignored
        send_text("079");                   // octal by leading zero, '9' pushed back
        send_byte(8'h00, 1'b1);
        send_text("+");
        send_byte(8'h00, 1'b1);             // lone sign: value 0, one character
        send_byte("A", 1'b1);               // input ends before any field
    endtask

    task automatic test_width_and_digits();
        apply_settings(BASE_AUTO, 6'd1);
        send_text("-7");                    // width reached on the sign, then on a digit
        apply_settings(BASE_AUTO, 6'd2);
        send_text("0x");                    // width reached inside the hex prefix
        apply_settings(BASE_HEX, 6'd0);
        send_text("x1x");                   // leading 'x' as zero digit, later 'x' rejected
        send_byte(8'h80, 1'b1);
        apply_settings(BASE_OCT, 6'd63);
        send_text("-9");                    // digit out of range for octal
    endtask

    task automatic test_random_fields();
        int          stop_at;
        int          phase_no;
        logic [5:0]  width;
        stop_at  = bytes_accepted + RANDOM_ITEMS;
        phase_no = 0;
        while (bytes_accepted < stop_at) begin
            case (phase_no % 6)
                0:       width = 6'd0;
                1:       width = 6'd1;
                2:       width = 6'd32;
                3:       width = 6'd63;
                default: width = 6'($urandom_range(2, 33));
            endcase
            no_idle = 1'b0;   // settle under normal idling
            apply_settings(2'(phase_no % 4), width);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6))
                send_field();
            phase_no++;
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, every output transfer checked in order
    // ------------------------------------------------------------------
    initial begin
        t_out_item want;
        int        stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                $error("result with no field pending: value %0d, count %0d",
                       o_out_item.field_value, o_out_item.chars_taken);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                fields_checked++;
                if (o_out_item.field_value !== want.field_value) begin
                    $error("field_value: expected %0d, got %0d",
                           want.field_value, o_out_item.field_value);
                    fail_count++;
                end
                if (o_out_item.chars_taken !== want.chars_taken) begin
                    $error("chars_taken: expected %0d, got %0d",
                           want.chars_taken, o_out_item.chars_taken);
                    fail_count++;
                end
                if (o_out_item.char_consumed !== want.char_consumed) begin
                    $error("char_consumed: expected %0b, got %0b",
                           want.char_consumed, o_out_item.char_consumed);
                    fail_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        cur_base_mode = BASE_AUTO;
        cur_max_width = '0;
        clear_field();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_fields();
        test_width_and_digits();
        test_random_fields();
        settle();

        $display("run covered %0d input transfers and %0d checked fields over %0d register settings",
                 bytes_accepted, fields_checked, settings_used);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
